>>> src/free_block_bitmap_allocator_top_assert.svh
// assertion macros used by the allocator checker
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FBBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FBBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fbba_pkg.sv
// types, codes and defaults of the free block bitmap allocator
package fbba_pkg;

  localparam int BLOCK_COUNT_DEF     = 65536;
  localparam int MAP_WORD_BITS_DEF   = 32;
  localparam int RESERVED_BLOCKS_DEF = 8;

  // blocks that the 16-bit index field can name
  localparam int INDEX_SPAN = 65536;
  localparam int INDEX_BITS = 16;

  // full summary: one bit per map word, packed in words of this size
  localparam int SUM_BITS = 32;
  localparam int SUM_SEL  = 5;

  typedef enum logic [1:0] {
    ACT_FIND  = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_CHECK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_REJECT      = 2'd1,
    STAT_NOT_WRITTEN = 2'd2,
    STAT_NO_FREE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_MUL,
    S_DIV_FIX,
    S_RMW_RD,
    S_RMW_WR,
    S_FIND_RD,
    S_FIND_SCAN,
    S_FIND_MAP,
    S_REPLY
  } state_e;

  typedef struct packed {
    action_e                 action;
    logic [INDEX_BITS-1:0]   block_index;
  } fbba_req_t;

  typedef struct packed {
    status_e                 status;
    logic [INDEX_BITS-1:0]   found_index;
  } fbba_rsp_t;

endpackage

>>> src/free_block_bitmap_allocator_top.sv
// free block bitmap allocator: used map and full summary in block memories
//
// requests enter on in_valid_i / in_stall_o with an fbba_req_t payload; one
// response per request leaves on out_valid_o / out_stall_i as fbba_rsp_t.
// one request is in work at a time; the response sits in an output register,
// so the next request is taken while a response still waits on a stall.
// steps from accept to out_valid_o:
//   reserved or nonexistent block: rejected in idle, then the reply
//   mark, erase, check: reciprocal divide, map read, write back (not for check)
//   find free: summary words are scanned one per cycle through the summary
//     memory read port, 1 to SUM_WORDS of them (64 at the default size); the
//     map word is then read once
// a stalled response holds out_valid_o and its payload; in_stall_o stays high
// until the pending response has moved into the output register.
// after reset a clearing pass writes every map word (MEM_WORDS words, 2048 at
// the default size) with the reserved blocks set and the summary alongside;
// in_stall_o is high during the pass.
module free_block_bitmap_allocator_top #(
  parameter int BLOCK_COUNT     = fbba_pkg::BLOCK_COUNT_DEF,
  parameter int MAP_WORD_BITS   = fbba_pkg::MAP_WORD_BITS_DEF,
  parameter int RESERVED_BLOCKS = fbba_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbba_pkg::fbba_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fbba_pkg::fbba_rsp_t out_rsp_o
);
  import fbba_pkg::*;

  localparam int LIMIT     = (BLOCK_COUNT < INDEX_SPAN) ? BLOCK_COUNT : INDEX_SPAN;
  localparam int MEM_WORDS = (LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SUM_WORDS = (MEM_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int SAW       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int BW        = $clog2(MAP_WORD_BITS);
  localparam int RECIP     = INDEX_SPAN / MAP_WORD_BITS;
  localparam int RW        = $clog2(RECIP + 1);
  localparam int PW        = INDEX_BITS + RW;
  localparam int FULL_AT_RESET = (LIMIT <= RESERVED_BLOCKS) ? MEM_WORDS
                                                           : RESERVED_BLOCKS / MAP_WORD_BITS;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [SUM_BITS-1:0]      sum_word_t;

  // reset contents of a map word: reserved blocks set
  function automatic map_word_t reset_word(input logic [AW-1:0] w);
    map_word_t v;
    v = '0;
    for (int s = 0; s < MAP_WORD_BITS; s++) begin
      v[s] = (int'(w) * MAP_WORD_BITS + s) < RESERVED_BLOCKS;
    end
    return v;
  endfunction

  // reset contents of a summary word; padding beyond the map reads as full
  function automatic sum_word_t sum_reset(input logic [AW-1:0] e);
    sum_word_t v;
    int        wd;
    v = '0;
    for (int t = 0; t < SUM_BITS; t++) begin
      wd   = int'(e) * SUM_BITS + t;
      v[t] = (wd >= MEM_WORDS) || (wd < FULL_AT_RESET);
    end
    return v;
  endfunction

  // bits of a map word that lie beyond the reachable blocks
  function automatic map_word_t pad_mask(input logic [AW-1:0] w);
    map_word_t v;
    int        base;
    v    = '0;
    base = int'(w) * MAP_WORD_BITS;
    for (int s = 0; s < MAP_WORD_BITS; s++) begin
      v[s] = (base + s) >= LIMIT;
    end
    return v;
  endfunction

  function automatic logic [BW-1:0] fz_map(input map_word_t v);
    logic [BW-1:0] r;
    r = '0;
    for (int s = MAP_WORD_BITS - 1; s >= 0; s--) begin
      if (!v[s]) r = BW'(s);
    end
    return r;
  endfunction

  function automatic logic [SUM_SEL-1:0] fz_sum(input sum_word_t v);
    logic [SUM_SEL-1:0] r;
    r = '0;
    for (int t = SUM_BITS - 1; t >= 0; t--) begin
      if (!v[t]) r = SUM_SEL'(t);
    end
    return r;
  endfunction

  // memories
  map_word_t map_mem [MEM_WORDS];
  sum_word_t sum_mem [SUM_WORDS];

  logic            map_we, map_re;
  logic [AW-1:0]   map_waddr, map_raddr;
  map_word_t       map_wdata, map_rdata_q;
  logic            sum_we, sum_re;
  logic [SAW-1:0]  sum_waddr, sum_raddr;
  sum_word_t       sum_wdata, sum_rdata_q;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata_q <= sum_mem[sum_raddr];
  end

  // control and datapath registers
  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic                   out_valid_q, out_valid_d;
  fbba_rsp_t              out_q, out_d;
  fbba_rsp_t              res_q, res_d;
  logic [INDEX_BITS-1:0]  blk_q, blk_d;
  action_e                act_q, act_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [AW-1:0]          word_q, word_d;
  logic [BW-1:0]          bit_q, bit_d;
  logic [SAW-1:0]         scan_q, scan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    res_q  <= res_d;
    blk_q  <= blk_d;
    act_q  <= act_d;
    prod_q <= prod_d;
    word_q <= word_d;
    bit_q  <= bit_d;
    scan_q <= scan_d;
  end

  // divide by the word size: reciprocal estimate, then one correction
  logic [RW-1:0]   quot_est;
  logic [16:0]     quot_back, rem_est;
  logic            rem_over;
  logic [AW-1:0]   div_word;
  logic [BW-1:0]   div_bit;

  always_comb begin
    quot_est  = prod_q[PW-1:INDEX_BITS];
    quot_back = 17'(quot_est * MAP_WORD_BITS);
    rem_est   = {1'b0, blk_q} - quot_back;
    rem_over  = rem_est >= 17'(MAP_WORD_BITS);
    div_word  = rem_over ? AW'(quot_est + 1'b1) : AW'(quot_est);
    div_bit   = rem_over ? BW'(rem_est - 17'(MAP_WORD_BITS)) : BW'(rem_est);
  end

  // read-modify-write values for mark and erase, and the scan values for find
  logic [SAW-1:0]     sum_idx;
  logic [SUM_SEL-1:0] sum_bit;
  map_word_t          bit_sel, map_new;
  sum_word_t          sum_new;
  logic               word_full;
  logic [SUM_SEL-1:0] scan_bit;
  logic [AW-1:0]      scan_word;
  logic [BW-1:0]      free_bit;

  always_comb begin
    sum_idx   = SAW'(word_q >> SUM_SEL);
    sum_bit   = SUM_SEL'(word_q);
    bit_sel   = map_word_t'(1) << bit_q;
    map_new   = (act_q == ACT_MARK) ? (map_rdata_q | bit_sel) : (map_rdata_q & ~bit_sel);
    word_full = &(map_new | pad_mask(word_q));
    sum_new          = sum_rdata_q;
    sum_new[sum_bit] = word_full;
    scan_bit  = fz_sum(sum_rdata_q);
    scan_word = AW'({scan_q, scan_bit});
    free_bit  = fz_map(map_rdata_q | pad_mask(word_q));
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    blk_d       = blk_q;
    act_d       = act_q;
    prod_d      = prod_q;
    word_d      = word_q;
    bit_d       = bit_q;
    scan_d      = scan_q;
    map_we      = 1'b0;
    map_waddr   = word_q;
    map_wdata   = map_new;
    map_re      = 1'b0;
    map_raddr   = word_q;
    sum_we      = 1'b0;
    sum_waddr   = sum_idx;
    sum_wdata   = sum_new;
    sum_re      = 1'b0;
    sum_raddr   = sum_idx;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = reset_word(clr_q);
        if (int'(clr_q) < SUM_WORDS) begin
          sum_we    = 1'b1;
          sum_waddr = SAW'(clr_q);
          sum_wdata = sum_reset(clr_q);
        end
        if (clr_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          blk_d = in_req_i.block_index;
          act_d = in_req_i.action;
          if (in_req_i.action == ACT_FIND) begin
            scan_d  = '0;
            state_d = S_FIND_RD;
          end else if (in_req_i.block_index < RESERVED_BLOCKS ||
                       in_req_i.block_index >= BLOCK_COUNT) begin
            res_d   = '{status: STAT_REJECT, found_index: '0};
            state_d = S_REPLY;
          end else begin
            state_d = S_DIV_MUL;
          end
        end
      end
      S_DIV_MUL: begin
        prod_d  = PW'(blk_q * RECIP);
        state_d = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        word_d  = div_word;
        bit_d   = div_bit;
        state_d = S_RMW_RD;
      end
      S_RMW_RD: begin
        map_re  = 1'b1;
        sum_re  = 1'b1;
        state_d = S_RMW_WR;
      end
      S_RMW_WR: begin
        if (act_q == ACT_CHECK) begin
          res_d.status = map_rdata_q[bit_q] ? STAT_OK : STAT_NOT_WRITTEN;
        end else begin
          map_we       = 1'b1;
          sum_we       = 1'b1;
          res_d.status = STAT_OK;
        end
        res_d.found_index = '0;
        state_d = S_REPLY;
      end
      S_FIND_RD: begin
        sum_re    = 1'b1;
        sum_raddr = scan_q;
        state_d   = S_FIND_SCAN;
      end
      S_FIND_SCAN: begin
        if (!(&sum_rdata_q)) begin
          word_d    = scan_word;
          map_re    = 1'b1;
          map_raddr = scan_word;
          state_d   = S_FIND_MAP;
        end else if (scan_q == SAW'(SUM_WORDS - 1)) begin
          res_d   = '{status: STAT_NO_FREE, found_index: '0};
          state_d = S_REPLY;
        end else begin
          // next summary word is read while this one is checked
          scan_d    = scan_q + 1'b1;
          sum_re    = 1'b1;
          sum_raddr = scan_q + 1'b1;
        end
      end
      S_FIND_MAP: begin
        res_d.status      = STAT_OK;
        res_d.found_index = INDEX_BITS'(int'(word_q) * MAP_WORD_BITS + int'(free_bit));
        state_d           = S_REPLY;
      end
      S_REPLY: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> src/fbba_checker.sv
// port-level checks of the free block bitmap allocator, bound to its top level
`include "free_block_bitmap_allocator_top_assert.svh"

module fbba_checker #(
  parameter int RESERVED_BLOCKS = fbba_pkg::RESERVED_BLOCKS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fbba_pkg::fbba_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fbba_pkg::fbba_rsp_t out_rsp_o
);
  import fbba_pkg::*;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  `FBBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "response dropped under stall")

  // one request at a time: stall rises right after an accept
  `FBBA_ASSERT_NEXT(a_one_in_work, in_acc, in_stall_o, "second request taken while one is in work")

  `FBBA_ASSERT_SAME(a_zero_index, out_valid_o && out_rsp_o.status != STAT_OK, out_rsp_o.found_index == '0, "nonzero index with failing status")

  // a found block is never one of the reserved map blocks
  `FBBA_ASSERT_SAME(a_not_reserved, out_acc && out_rsp_o.found_index != '0, out_rsp_o.found_index >= RESERVED_BLOCKS, "reserved block reported")

endmodule

bind free_block_bitmap_allocator_top fbba_checker #(
  .RESERVED_BLOCKS(RESERVED_BLOCKS)
) u_fbba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
